FILE: src/hfm_pkg.sv
`default_nettype none
package hfm_pkg;
	localparam int unsigned HalfWidth = 16;
	localparam int unsigned ExpWidth = 5;
	localparam int unsigned FracWidth = 10;
	localparam int unsigned SigWidth = 11;
	localparam int unsigned ProdWidth = 22;
	localparam logic [ExpWidth-1:0] ExpMax = 5'd31;
	localparam logic [6:0] ExpBias = 7'd15;
	localparam logic [FracWidth-1:0] NanFrac = 10'd1;

	// decoded operand class, passed from the front stage
	typedef struct packed {
		logic sign;
		logic is_nan;
		logic is_inf;
		logic is_zero;
		logic [6:0] exp_sum;
	} hfm_ctrl_t;
endpackage
`default_nettype wire

FILE: src/hfm_front.sv
`default_nettype none
module hfm_front (
	input wire logic [hfm_pkg::HalfWidth-1:0] operand_a,
	input wire logic [hfm_pkg::HalfWidth-1:0] operand_b,
	output hfm_pkg::hfm_ctrl_t ctrl,
	output logic [hfm_pkg::ProdWidth-1:0] sig_prod
);
	import hfm_pkg::*;
	logic [ExpWidth-1:0] ea, eb;
	logic [FracWidth-1:0] fa, fb;

	// field split and special-case decode
	always_comb begin
		ea = operand_a[14:10];
		eb = operand_b[14:10];
		fa = operand_a[9:0];
		fb = operand_b[9:0];
		ctrl.sign = operand_a[15] ^ operand_b[15];
		ctrl.is_nan = (ea == ExpMax && fa != '0) || (eb == ExpMax && fb != '0);
		ctrl.is_inf = (ea == ExpMax) || (eb == ExpMax);
		ctrl.is_zero = (ea == '0) || (eb == '0);
		ctrl.exp_sum = {2'b00, ea} + {2'b00, eb};
		sig_prod = {11'd0, 1'b1, fa} * {11'd0, 1'b1, fb};
	end
endmodule
`default_nettype wire

FILE: src/hfm_round.sv
`default_nettype none
module hfm_round (
	input wire hfm_pkg::hfm_ctrl_t ctrl,
	input wire logic [hfm_pkg::ProdWidth-1:0] sig_prod,
	output logic [hfm_pkg::HalfWidth-1:0] product
);
	import hfm_pkg::*;
	logic [7:0] e;
	logic [11:0] mant;
	logic guard, sticky, lsb;

	// normalize, round to nearest even, pack; NaN, infinity, zero, overflow and underflow override
	always_comb begin
		e = {1'b0, ctrl.exp_sum} - {1'b0, ExpBias};
		if (sig_prod[21]) begin
			e = e + 8'd1;
			mant = {1'b0, sig_prod[21:11]};
			guard = sig_prod[10];
			sticky = sig_prod[9:0] != '0;
		end else begin
			mant = {1'b0, sig_prod[20:10]};
			guard = sig_prod[9];
			sticky = sig_prod[8:0] != '0;
		end
		lsb = mant[0];
		if (guard && (sticky || lsb))
			mant = mant + 12'd1;
		if (mant[11]) begin
			mant = mant >> 1;
			e = e + 8'd1;
		end
		if (ctrl.is_nan)
			product = {ctrl.sign, ExpMax, NanFrac};
		else if (ctrl.is_inf)
			product = {ctrl.sign, ExpMax, 10'd0};
		else if (ctrl.is_zero)
			product = {ctrl.sign, 15'd0};
		else if (!e[7] && e >= 8'd31)
			product = {ctrl.sign, ExpMax, 10'd0};
		else if (e[7] || e == 8'd0)
			product = {ctrl.sign, 15'd0};
		else
			product = {ctrl.sign, e[4:0], mant[9:0]};
	end
endmodule
`default_nettype wire

FILE: src/half_float_multiplier_core.sv
`default_nettype none
// Channel  | Ports                          | Handshake
// input    | operand_a, operand_b           | start, accepted when !busy
// result   | product                        | done strobe, one cycle
// From accept to done: decode and 11x11 multiply into the
// stage-1 register, then normalize and round into the result register.
// One item per cycle; busy is tied low. Reset clears the strobes only.
// The receiver cannot stall; each result shows for exactly one cycle.
module half_float_multiplier_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [hfm_pkg::HalfWidth-1:0] operand_a,
	input wire logic [hfm_pkg::HalfWidth-1:0] operand_b,
	output logic done,
	output logic [hfm_pkg::HalfWidth-1:0] product
);
	import hfm_pkg::*;
	hfm_ctrl_t ctrl_c, ctrl_s1;
	logic [ProdWidth-1:0] prod_c, prod_s1;
	logic [HalfWidth-1:0] product_c;
	logic valid_s1;

	assign busy = 1'b0;

	hfm_front u_front (.operand_a(operand_a), .operand_b(operand_b),
		.ctrl(ctrl_c), .sig_prod(prod_c));

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_c;
		prod_s1 <= prod_c;
	end

	hfm_round u_round (.ctrl(ctrl_s1), .sig_prod(prod_s1), .product(product_c));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= valid_s1;
	end
	always_ff @(posedge clk) begin
		product <= product_c;
	end

`ifndef NO_ASSERTIONS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done) else $error("item lost");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2)) else $error("spurious result");
	a_nan_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctrl_s1.is_nan |=> product[14:0] == {ExpMax, NanFrac})
		else $error("nan encoding");
`endif
endmodule
`default_nettype wire

FILE: bench/hfm_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module hfm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [15:0] operand_a,
	input wire logic [15:0] operand_b,
	input wire logic done,
	input wire logic [15:0] product,
	output int unsigned errors,
	output int unsigned pending
);
	logic [15:0] product_q[$];

	// half multiply with flush-to-zero and round to nearest even
	function automatic logic [15:0] half_product(input logic [15:0] a, input logic [15:0] b);
		logic sgn;
		logic [4:0] ea, eb;
		logic [9:0] fa, fb;
		logic [21:0] p;
		logic [11:0] sig;
		logic grd, stk, lsb;
		int e;
		sgn = a[15] ^ b[15];
		ea = a[14:10]; eb = b[14:10];
		fa = a[9:0]; fb = b[9:0];
		if ((ea == hfm_pkg::ExpMax && fa != 0) || (eb == hfm_pkg::ExpMax && fb != 0))
			return {sgn, hfm_pkg::ExpMax, hfm_pkg::NanFrac};
		if (ea == hfm_pkg::ExpMax || eb == hfm_pkg::ExpMax)
			return {sgn, hfm_pkg::ExpMax, 10'd0};
		if (ea == 0 || eb == 0)
			return {sgn, 15'd0};
		e = int'(ea) + int'(eb) - 15;
		if (e >= 31)
			return {sgn, hfm_pkg::ExpMax, 10'd0};
		p = {1'b1, fa} * {1'b1, fb};
		if (p[21]) begin
			e++;
			sig = {1'b0, p[21:11]};
			grd = p[10]; stk = |p[9:0]; lsb = p[11];
		end else begin
			sig = {1'b0, p[20:10]};
			grd = p[9]; stk = |p[8:0]; lsb = p[10];
		end
		if (grd && (stk || lsb))
			sig++;
		if (sig[11]) begin
			sig = sig >> 1;
			e++;
		end
		if (e >= 31)
			return {sgn, hfm_pkg::ExpMax, 10'd0};
		if (e <= 0)
			return {sgn, 15'd0};
		return {sgn, e[4:0], sig[9:0]};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	initial errors = 0;
	assign pending = product_q.size();

	// predict on accept, compare on strobe
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n) begin
			if (done) begin
				if (product_q.size() == 0) begin
					report_mismatch($sformatf("unexpected product %h", product));
				end else begin
					want = product_q.pop_front();
					if (product !== want)
						report_mismatch($sformatf("product %h, want %h", product, want));
				end
			end
			if (start && !busy)
				product_q.push_back(half_product(operand_a, operand_b));
		end
	end

	final if (product_q.size() != 0) $display("%0d products never arrived", product_q.size());
endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	logic clk, arst_n, start, busy, done;
	logic [15:0] operand_a, operand_b, product;
	int unsigned errors, pending, quiet;
	int n;

	half_float_multiplier_core i_dut (.clk, .arst_n, .start, .busy,
		.operand_a, .operand_b, .done, .product);
	hfm_checker i_chk (.clk, .arst_n, .start, .busy, .operand_a, .operand_b,
		.done, .product, .errors, .pending);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any accept or result
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 2000) begin
			$display("FAIL");
			$finish;
		end
	end

	// random operand biased toward special exponents
	function automatic logic [15:0] pick_half();
		logic [4:0] e;
		case ($urandom_range(0, 9))
			0: e = 5'd0;
			1: e = 5'd31;
			2: e = 5'($urandom_range(1, 4));
			3: e = 5'($urandom_range(27, 30));
			default: e = 5'($urandom_range(8, 22));
		endcase
		return {1'($urandom), e, 10'($urandom)};
	endfunction

	task automatic send(input logic [15:0] a, input logic [15:0] b, input bit idle_ok);
		while (idle_ok && $urandom_range(0, 99) < 21) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] dir[$] = '{16'h3C00, 16'h3C00, 16'h7C01, 16'h3C00, 16'h3C00, 16'hFE00,
			16'h7C00, 16'h0000, 16'hFC00, 16'h4000, 16'h0000, 16'h3C00, 16'h03FF, 16'h3C00,
			16'h7BFF, 16'h7BFF, 16'h7800, 16'h4000, 16'h3FFF, 16'h3FFF, 16'h3C01, 16'h3C01,
			16'h0400, 16'h0400, 16'h2000, 16'h2000, 16'h0401, 16'h3BFF, 16'hFBFF, 16'h3C00,
			16'hFFFF, 16'hFFFF};
		quiet = 0; arst_n = 0; start = 0; operand_a = 0; operand_b = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int i = 0; i < dir.size(); i += 2) send(dir[i], dir[i+1], 0);
		for (n = 0; n < 800; n++) begin
			if (n < 200) send(pick_half(), pick_half(), 0);
			else if ($urandom_range(0, 3) == 0) send(16'($urandom), 16'($urandom), 1);
			else send(pick_half(), pick_half(), 1);
		end
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
